// File: rtl/core/lrz_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared types and constants for the line rasterizer and its depth divider.
// ----------------------------------------------------------------------------
package lrz_pkg;

	localparam int CoordW    = 6;
	localparam int DepthW    = 32;
	localparam int ColorW    = 24;
	localparam int ObjW      = 16;
	localparam int InDataW   = 88;
	localparam int OutDataW  = 88;

	// Command kind carried on the input tuser.
	typedef enum logic {
		FUNC_MOVE = 1'b0,
		FUNC_DRAW = 1'b1
	} func_t;

	// Request to the depth step divider: magnitude of the depth difference,
	// the step count and the sign to apply to the quotient.
	typedef struct packed {
		logic                start;
		logic                neg;
		logic [DepthW-1:0]   dividend;
		logic [CoordW-1:0]   divisor;
	} div_req_t;

endpackage

// File: rtl/core/lrz_div.sv
// ----------------------------------------------------------------------------
// Depth step divider
// Restoring radix-2 divider, one quotient bit per cycle, signed result.
// ----------------------------------------------------------------------------
module lrz_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lrz_pkg::div_req_t                 req,
	output logic                              done,
	output logic [lrz_pkg::DepthW-1:0]        quotient
);

	localparam int Iter = lrz_pkg::DepthW;
	localparam int CntW = $clog2(Iter);
	localparam logic [CntW-1:0] LastCnt = CntW'(Iter - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CntW-1:0]               cnt_q;
	logic [lrz_pkg::CoordW-1:0]    rem_q;
	logic [lrz_pkg::CoordW-1:0]    den_q;
	logic [lrz_pkg::DepthW-1:0]    quo_q;
	logic                          neg_q;

	logic [lrz_pkg::CoordW:0]      trial;
	logic                          fits;
	logic [lrz_pkg::CoordW:0]      diff;

	// The dividend shifts out of the top of quo_q while quotient bits enter
	// at the bottom, so one register serves both.
	assign trial = {rem_q, quo_q[lrz_pkg::DepthW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LastCnt) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= fits ? diff[lrz_pkg::CoordW-1:0] : trial[lrz_pkg::CoordW-1:0];
			quo_q <= {quo_q[lrz_pkg::DepthW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// File: rtl/core/line_rasterizer_with_depth.sv
// ----------------------------------------------------------------------------
// Line rasterizer with depth interpolation
// Pen-style Bresenham line drawer that emits one pixel per transfer.
// ----------------------------------------------------------------------------
// Commands arrive on the slave stream (s_*); s_tuser selects a pen move or a
// line draw. A move only updates the stored pen position and depth and gives
// no output; the block is ready for the next command in the following cycle.
// A draw rasterizes the line from the pen to the new endpoint, then moves the
// pen there. Pixels leave on the master stream (m_*), one transfer per pixel,
// with m_tlast on the final pixel of the line. A line of major span N gives
// N+1 pixels; a zero-length line gives one.
// The per-pixel depth step comes from a restoring divider that retires one
// quotient bit per cycle. After the command transfer a draw passes through
// ST_PREP, where the divider starts, and ST_DIV until the quotient is done,
// and then offers its first pixel in ST_EMIT; a zero-length line skips the
// divider and goes straight to ST_EMIT. From there the pixel sequencer emits
// one pixel per cycle as long as m_tready is high; when the receiver stalls,
// the current pixel is held on m_tdata and stepping pauses. s_tready stays
// low from the accepted draw until the last pixel transfer completes.
// Reset clears the pen to the origin with zero depth and leaves the block idle.
// Endpoint coordinates above TILE_SIZE-1 are saturated to TILE_SIZE-1.
// ----------------------------------------------------------------------------
module line_rasterizer_with_depth #(
	parameter int TILE_SIZE = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tdata: end_x[5:0], end_y[11:6], end_z[43:12], color[67:44],
	//        object_id[83:68], force_req[84], zero pad[87:85]
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lrz_pkg::InDataW-1:0]      s_tdata,
	// tuser: func[0]
	input  logic                             s_tuser,
	// tdata: pixel_x[5:0], pixel_y[11:6], pixel_z[43:12], pixel_color[67:44],
	//        pixel_object[83:68], pixel_force[84], zero pad[87:85]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lrz_pkg::OutDataW-1:0]     m_tdata,
	output logic                             m_tlast
);

	localparam int CW = lrz_pkg::CoordW;
	localparam int ZW = lrz_pkg::DepthW;
	localparam logic [CW-1:0] MaxCoord = CW'(TILE_SIZE - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Pen state.
	logic [CW-1:0] pen_x_q;
	logic [CW-1:0] pen_y_q;
	logic [ZW-1:0] pen_z_q;

	// Run registers: the current pixel doubles as the output register.
	logic [CW-1:0]             cx_q;
	logic [CW-1:0]             cy_q;
	logic [ZW-1:0]             cz_q;
	logic [ZW-1:0]             fz_q;
	logic [ZW-1:0]             dz_q;
	logic                      xmaj_q;
	logic                      mneg_q;
	logic [CW-1:0]             major_q;
	logic [CW-1:0]             minor_q;
	logic signed [CW+2:0]      d_q;
	logic [CW-1:0]             k_q;
	logic                      last_q;
	logic [lrz_pkg::ColorW-1:0] color_q;
	logic [lrz_pkg::ObjW-1:0]  obj_q;
	logic                      force_q;

	// Fields of the incoming command.
	logic [CW-1:0] in_x;
	logic [CW-1:0] in_y;
	logic [ZW-1:0] in_z;
	logic          in_draw;

	logic [CW-1:0] ex_c;
	logic [CW-1:0] ey_c;
	logic [CW-1:0] adx_c;
	logic [CW-1:0] ady_c;
	logic          xmaj_c;
	logic          fwd_c;
	logic          mneg_c;
	logic [CW-1:0] major_c;
	logic [CW-1:0] minor_c;

	logic signed [CW+2:0] inc_a;
	logic signed [CW+2:0] inc_b;
	logic [CW-1:0]        k_next;

	logic [ZW:0]               diff_c;
	logic                      in_xfer;
	logic                      out_xfer;
	lrz_pkg::div_req_t         div_req;
	logic                      div_done;
	logic [ZW-1:0]             div_q;

	assign in_x    = s_tdata[5:0];
	assign in_y    = s_tdata[11:6];
	assign in_z    = s_tdata[43:12];
	assign in_draw = (s_tuser == lrz_pkg::FUNC_DRAW);

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign out_xfer = m_tvalid && m_tready;

	// Saturate the endpoint into the tile, then pick the major axis (y on a
	// tie) and order the ends so that the major coordinate rises.
	always_comb begin
		ex_c    = (in_x > MaxCoord) ? MaxCoord : in_x;
		ey_c    = (in_y > MaxCoord) ? MaxCoord : in_y;
		adx_c   = (ex_c >= pen_x_q) ? (ex_c - pen_x_q) : (pen_x_q - ex_c);
		ady_c   = (ey_c >= pen_y_q) ? (ey_c - pen_y_q) : (pen_y_q - ey_c);
		xmaj_c  = adx_c > ady_c;
		fwd_c   = xmaj_c ? (ex_c > pen_x_q) : (ey_c > pen_y_q);
		if (fwd_c) begin
			mneg_c = xmaj_c ? (ey_c < pen_y_q) : (ex_c < pen_x_q);
		end else begin
			mneg_c = xmaj_c ? (pen_y_q < ey_c) : (pen_x_q < ex_c);
		end
		major_c = xmaj_c ? adx_c : ady_c;
		minor_c = xmaj_c ? ady_c : adx_c;
	end

	// Bresenham decision increments.
	assign inc_a  = $signed({2'b00, minor_q, 1'b0});
	assign inc_b  = inc_a - $signed({2'b00, major_q, 1'b0});
	assign k_next = k_q + 1'b1;

	// The depth difference is formed in the cycle after the draw, once the
	// start and far depths sit in registers, and feeds the divider in ST_PREP.
	assign diff_c = {fz_q[ZW-1], fz_q} - {cz_q[ZW-1], cz_q};

	always_comb begin
		div_req          = '0;
		div_req.start    = (state_q == ST_PREP);
		div_req.neg      = diff_c[ZW];
		div_req.dividend = diff_c[ZW] ? (~diff_c[ZW-1:0] + 1'b1) : diff_c[ZW-1:0];
		div_req.divisor  = major_q;
	end

	lrz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_q)
	);

	// Control and pen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pen_x_q <= '0;
			pen_y_q <= '0;
			pen_z_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						pen_x_q <= ex_c;
						pen_y_q <= ey_c;
						pen_z_q <= in_z;
						if (in_draw) begin
							// A zero-length line needs no depth step.
							state_q <= (major_c == '0) ? ST_EMIT : ST_PREP;
						end
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_xfer && last_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Run datapath.
	always_ff @(posedge clk) begin
		if (in_xfer && in_draw) begin
			cx_q    <= fwd_c ? pen_x_q : ex_c;
			cy_q    <= fwd_c ? pen_y_q : ey_c;
			cz_q    <= fwd_c ? pen_z_q : in_z;
			fz_q    <= fwd_c ? in_z : pen_z_q;
			xmaj_q  <= xmaj_c;
			mneg_q  <= mneg_c;
			major_q <= major_c;
			minor_q <= minor_c;
			d_q     <= $signed({2'b00, minor_c, 1'b0}) - $signed({3'b000, major_c});
			k_q     <= '0;
			last_q  <= (major_c == '0);
			color_q <= s_tdata[67:44];
			obj_q   <= s_tdata[83:68];
			force_q <= s_tdata[84];
		end
		if (div_done && state_q == ST_DIV) begin
			dz_q <= div_q;
		end
		if (out_xfer && !last_q) begin
			if (d_q < 0) begin
				d_q <= d_q + inc_a;
			end else begin
				d_q <= d_q + inc_b;
				if (xmaj_q) begin
					cy_q <= mneg_q ? (cy_q - 1'b1) : (cy_q + 1'b1);
				end else begin
					cx_q <= mneg_q ? (cx_q - 1'b1) : (cx_q + 1'b1);
				end
			end
			if (xmaj_q) begin
				cx_q <= cx_q + 1'b1;
			end else begin
				cy_q <= cy_q + 1'b1;
			end
			cz_q   <= cz_q + dz_q;
			k_q    <= k_next;
			last_q <= (k_next == major_q);
		end
	end

	assign m_tdata = {3'b000, force_q, obj_q, color_q, cz_q, cy_q, cx_q};
	assign m_tlast = last_q;

endmodule

// File: rtl/core/lrz_checker.sv
// ----------------------------------------------------------------------------
// Line rasterizer port checker
// Temporal checks on the rasterizer's stream ports, bound to the top level.
// ----------------------------------------------------------------------------
module lrz_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [lrz_pkg::InDataW-1:0]       s_tdata,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lrz_pkg::OutDataW-1:0]      m_tdata,
	input logic                              m_tlast
);

	// Pixels are only produced while no new command can be taken.
	a_busy_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("command accepted while a pixel is pending");

	// A stalled pixel keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("pixel changed while stalled");

	// A pen move produces no pixel and leaves the block ready.
	a_move_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == lrz_pkg::FUNC_MOVE) |=> s_tready && !m_tvalid)
		else $error("pen move produced output or stalled");

	// A draw always keeps the block busy in the next cycle.
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == lrz_pkg::FUNC_DRAW) |=> !s_tready)
		else $error("draw did not occupy the block");

	// The last pixel ends the line and returns the block to idle.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("output continued after the last pixel");

endmodule

bind line_rasterizer_with_depth lrz_checker u_lrz_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line rasterizer with depth testbench
// Sends pen moves and line draws, predicts every pixel and checks each one.
// ----------------------------------------------------------------------------
// A short table of hand-picked commands comes first. It covers full-tile
// horizontal, vertical and diagonal lines, both end orders on each axis,
// zero-length lines and the depth extremes. For the zero-length rows the
// single pixel is typed into the table. Every other row, and the random
// commands after the table, are checked against a behavioral line model
// kept in this file. The model tracks its own copy of the pen. Both stream
// sides idle at random, with one stretch free of idling. The sender also
// holds off three times until every pixel it is owed has arrived.
// ----------------------------------------------------------------------------
module tb;

	localparam int RAND_ITEMS = 100;
	localparam int DIR_ROWS   = 21;

	// One command as the sender sees it.
	typedef struct packed {
		lrz_pkg::func_t func;
		logic [5:0]     x;
		logic [5:0]     y;
		logic [31:0]    z;
		logic [23:0]    color;
		logic [15:0]    obj;
		logic           frc;
	} cmd_t;

	// One pixel transfer on the master side.
	typedef struct packed {
		logic [5:0]  x;
		logic [5:0]  y;
		logic [31:0] z;
		logic [23:0] color;
		logic [15:0] obj;
		logic        frc;
		logic        last;
	} pixel_t;

	// A row of the directed table. When "typed" is set, the single pixel in
	// "px" is expected instead of what the line model would produce.
	typedef struct packed {
		cmd_t   cmd;
		logic   typed;
		pixel_t px;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// Zero-length line at the origin right after reset, depth at the positive maximum, other fields high.
		'{'{lrz_pkg::FUNC_DRAW, 6'd0, 6'd0, 32'h7FFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 1'b1},
		  1'b1, '{6'd0, 6'd0, 32'h7FFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 1'b1, 1'b1}},
		// Full-width horizontal line, depth swinging across the whole range.
		'{'{lrz_pkg::FUNC_DRAW, 6'd63, 6'd0, 32'h8000_0000, 24'h00_0000, 16'h0000, 1'b0},
		  1'b0, '0},
		// Full-height vertical line back up to the top of the range.
		'{'{lrz_pkg::FUNC_DRAW, 6'd63, 6'd63, 32'h7FFF_FFFF, 24'h12_3456, 16'h0001, 1'b1},
		  1'b0, '0},
		// Equal spans: y is the major axis, the run starts at the new endpoint.
		'{'{lrz_pkg::FUNC_DRAW, 6'd0, 6'd0, 32'h0000_0000, 24'hAB_CDEF, 16'h8000, 1'b0},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_MOVE, 6'd10, 6'd50, 32'h0001_0000, 24'h55_AA55, 16'h1234, 1'b1},
		  1'b0, '0},
		// x major, run starts at the pen, minor axis falling.
		'{'{lrz_pkg::FUNC_DRAW, 6'd50, 6'd20, 32'hFFFF_0000, 24'h0F_0F0F, 16'h4321, 1'b1},
		  1'b0, '0},
		// Same line reversed, so the run starts at the new endpoint.
		'{'{lrz_pkg::FUNC_DRAW, 6'd10, 6'd50, 32'h0002_0000, 24'hF0_F0F0, 16'h00FF, 1'b0},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_MOVE, 6'd63, 6'd63, 32'h8000_0000, 24'h00_0000, 16'h0000, 1'b0},
		  1'b0, '0},
		// Zero-length line at the far corner after a move.
		'{'{lrz_pkg::FUNC_DRAW, 6'd63, 6'd63, 32'h1234_5678, 24'hC0_FFEE, 16'hBEEF, 1'b0},
		  1'b1, '{6'd63, 6'd63, 32'h1234_5678, 24'hC0_FFEE, 16'hBEEF, 1'b0, 1'b1}},
		'{'{lrz_pkg::FUNC_DRAW, 6'd0, 6'd62, 32'h0000_0000, 24'h80_0000, 16'h7FFF, 1'b1},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_DRAW, 6'd1, 6'd0, 32'hFFFF_FFFF, 24'h00_0001, 16'hFFFE, 1'b0},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_MOVE, 6'd32, 6'd32, 32'h0001_0000, 24'h33_3333, 16'h0F0F, 1'b0},
		  1'b0, '0},
		// Short steep line and its reverse.
		'{'{lrz_pkg::FUNC_DRAW, 6'd33, 6'd40, 32'h0005_0000, 24'h44_4444, 16'hF0F0, 1'b1},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_DRAW, 6'd32, 6'd32, 32'hFFFB_0000, 24'h66_6666, 16'h5555, 1'b0},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_DRAW, 6'd0, 6'd63, 32'hFFFF_0000, 24'h77_7777, 16'hAAAA, 1'b1},
		  1'b0, '0},
		// Anti-diagonal across the whole tile.
		'{'{lrz_pkg::FUNC_DRAW, 6'd63, 6'd0, 32'h7FFF_FFFF, 24'h99_9999, 16'h0100, 1'b0},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_DRAW, 6'd5, 6'd5, 32'hFFFF_FFFF, 24'hAA_AAAA, 16'h0200, 1'b1},
		  1'b0, '0},
		// Short line with a depth step that truncates to zero.
		'{'{lrz_pkg::FUNC_DRAW, 6'd5, 6'd10, 32'h0000_0002, 24'hBB_BBBB, 16'h0400, 1'b0},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_MOVE, 6'd0, 6'd0, 32'h0000_0000, 24'hCC_CCCC, 16'h0800, 1'b1},
		  1'b0, '0},
		'{'{lrz_pkg::FUNC_DRAW, 6'd0, 6'd0, 32'h0000_0001, 24'hDD_DDDD, 16'h1000, 1'b0},
		  1'b1, '{6'd0, 6'd0, 32'h0000_0001, 24'hDD_DDDD, 16'h1000, 1'b0, 1'b1}},
		// One x step with the most negative depth at the far end.
		'{'{lrz_pkg::FUNC_DRAW, 6'd1, 6'd0, 32'h8000_0000, 24'hEE_EEEE, 16'h2000, 1'b1},
		  1'b0, '0}
	};

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [lrz_pkg::InDataW-1:0]  s_tdata  = '0;
	logic                         s_tuser  = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [lrz_pkg::OutDataW-1:0] m_tdata;
	logic                         m_tlast;

	// The pen as this testbench believes it to be.
	logic [5:0]  pos_x;
	logic [5:0]  pos_y;
	logic [31:0] pos_depth;

	pixel_t pixels_due[$];
	int     pixel_errors = 0;
	// While set, neither side idles.
	bit     steady = 1'b0;

	line_rasterizer_with_depth dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Behavioral line drawer. A move only updates the pen. A draw orders the
	// two ends so that the major coordinate rises, steps with the usual
	// integer decision variable and adds a fixed depth step per pixel. The
	// depth step is the exact difference divided by the step count, truncated
	// toward zero, so every pixel depth stays between the two end depths.
	function automatic void raster_line(input cmd_t cmd, ref pixel_t out_q[$]);
		int     ax, ay, bx, by, adx, ady;
		int     sx, sy, fx, fy;
		int     major, minor, minc, d, steps, k;
		longint sz, fz, dz, cz;
		bit     x_major;
		pixel_t px;
		if (cmd.func == lrz_pkg::FUNC_MOVE) begin
			pos_x     = cmd.x;
			pos_y     = cmd.y;
			pos_depth = cmd.z;
			return;
		end
		ax = cmd.x;
		ay = cmd.y;
		bx = pos_x;
		by = pos_y;
		adx = (ax > bx) ? ax - bx : bx - ax;
		ady = (ay > by) ? ay - by : by - ay;
		// On equal spans y is the major axis.
		x_major = adx > ady;
		if ((x_major && ax > bx) || (!x_major && ay > by)) begin
			sx = bx;
			sy = by;
			sz = longint'($signed(pos_depth));
			fx = ax;
			fy = ay;
			fz = longint'($signed(cmd.z));
		end else begin
			sx = ax;
			sy = ay;
			sz = longint'($signed(cmd.z));
			fx = bx;
			fy = by;
			fz = longint'($signed(pos_depth));
		end
		major = x_major ? fx - sx : fy - sy;
		minor = x_major ? fy - sy : fx - sx;
		minc  = 1;
		if (minor < 0) begin
			minc  = -1;
			minor = -minor;
		end
		steps = major;
		dz    = (steps > 0) ? (fz - sz) / steps : 0;
		d     = 2 * minor - major;
		cz    = sz;
		for (k = 0; k <= steps; k++) begin
			if (k > 0) begin
				if (d < 0) begin
					d += 2 * minor;
				end else begin
					d += 2 * (minor - major);
					if (x_major)
						sy += minc;
					else
						sx += minc;
				end
				if (x_major)
					sx += 1;
				else
					sy += 1;
				cz += dz;
			end
			px.x     = sx[5:0];
			px.y     = sy[5:0];
			px.z     = cz[31:0];
			px.color = cmd.color;
			px.obj   = cmd.obj;
			px.frc   = cmd.frc;
			px.last  = (k == steps);
			out_q.push_back(px);
		end
		pos_x     = cmd.x;
		pos_y     = cmd.y;
		pos_depth = cmd.z;
	endfunction

	// Idle length before a command or on the pixel side: mostly none or a
	// short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// Endpoint coordinate: anywhere in the tile, close to the pen for short
	// lines, or on a tile edge.
	function automatic logic [5:0] pick_coord(input logic [5:0] base);
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 6'($urandom_range(0, 63));
		if (r < 90) begin
			v = int'(base) + int'($urandom_range(0, 8)) - 4;
			if (v < 0)
				v = 0;
			else if (v > 63)
				v = 63;
			return v[5:0];
		end
		return (r < 95) ? 6'd0 : 6'd63;
	endfunction

	// Depth: any value, a small value around zero, one of the two extremes, minus one or zero.
	function automatic logic [31:0] pick_depth();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom();
		if (r < 80)
			return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
		case ($urandom_range(0, 3))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			default: return 32'h0000_0000;
		endcase
	endfunction

	// Offers one command after a random idle gap and waits for its transfer.
	// The expected pixels are queued at the edge of the transfer; the first
	// pixel can leave no earlier than the next edge.
	task automatic issue(input cmd_t cmd, input logic typed, input pixel_t typed_px);
		pixel_t fresh[$];
		int     gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd.func;
		s_tdata  <= {3'b000, cmd.frc, cmd.obj, cmd.color, cmd.z, cmd.y, cmd.x};
		do @(posedge clk); while (!s_tready);
		raster_line(cmd, fresh);
		// A typed row still runs the model so that the pen stays in step.
		if (typed)
			pixels_due.push_back(typed_px);
		else
			foreach (fresh[j]) pixels_due.push_back(fresh[j]);
	endtask

	// Drops s_tvalid and waits on the clock before it first looks at the queue,
	// so the next command's drive never lands in the same time step as this one.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pixels_due.size() != 0);
	endtask

	// Command side.
	initial begin
		cmd_t cmd;
		int   i;
		pos_x     = '0;
		pos_y     = '0;
		pos_depth = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			issue(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].px);
		hold_until_drained();

		// Random commands, about a quarter of them pen moves. A stretch in
		// the middle runs with both sides at full rate.
		for (i = 0; i < RAND_ITEMS; i++) begin
			steady = (i >= 40 && i < 60);
			if (i == 60)
				hold_until_drained();
			cmd.func  = ($urandom_range(0, 99) < 25) ? lrz_pkg::FUNC_MOVE : lrz_pkg::FUNC_DRAW;
			cmd.x     = pick_coord(pos_x);
			cmd.y     = pick_coord(pos_y);
			cmd.z     = pick_depth();
			cmd.color = 24'($urandom());
			cmd.obj   = 16'($urandom());
			cmd.frc   = 1'($urandom());
			issue(cmd, 1'b0, '0);
		end
		hold_until_drained();

		// A draw passes through the divider before its first pixel, so anything
		// stray would show up within this window.
		repeat (40) @(posedge clk);
		if (pixel_errors == 0 && pixels_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Pixel side: random stalls on m_tready, at most one assignment per edge.
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap == 0) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Every pixel transfer is matched with the oldest pixel still due.
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[5:0], m_tdata[11:6], m_tdata[43:12], m_tdata[67:44],
				m_tdata[83:68], m_tdata[84], m_tlast};
			if (pixels_due.size() == 0) begin
				$error("pixel transfer with no pixel due: x %0d y %0d", got.x, got.y);
				pixel_errors++;
			end else begin
				want = pixels_due.pop_front();
				if (got.x !== want.x) begin
					$error("pixel_x: expected %0d, got %0d", want.x, got.x);
					pixel_errors++;
				end
				if (got.y !== want.y) begin
					$error("pixel_y: expected %0d, got %0d", want.y, got.y);
					pixel_errors++;
				end
				if (got.z !== want.z) begin
					$error("pixel_z: expected %h, got %h", want.z, got.z);
					pixel_errors++;
				end
				if (got.color !== want.color) begin
					$error("pixel_color: expected %h, got %h", want.color, got.color);
					pixel_errors++;
				end
				if (got.obj !== want.obj) begin
					$error("pixel_object: expected %h, got %h", want.obj, got.obj);
					pixel_errors++;
				end
				if (got.frc !== want.frc) begin
					$error("pixel_force: expected %b, got %b", want.frc, got.frc);
					pixel_errors++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, got.last);
					pixel_errors++;
				end
			end
		end
	end

	// Watchdog. The slowest correct run, every line at full length and
	// every pixel behind the longest stall, stays well below this.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
